### hdl/wmf2d_pkg.sv
// ----------------------------------------------------------------------------
// wmf2d_pkg
// Shared types and constants of the two-dimensional windowed median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package wmf2d_pkg;

  // Frame and window limits used as parameter defaults
  localparam int unsigned MaxWidthDef  = 64;
  localparam int unsigned MaxHeightDef = 64;
  localparam int unsigned MaxRadiusDef = 3;

  // Field widths fixed by the item format
  localparam int unsigned SampleW = 16;
  localparam int unsigned PosW    = 6;
  localparam int unsigned CoordW  = 7;   // holds a window corner past the frame edge
  localparam int unsigned DimW    = 7;
  localparam int unsigned RadW    = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned BitIdxW = $clog2(SampleW);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegImageWidth   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWindowRadius = 2'd2;

  localparam logic [DimW-1:0] ImageWidthRst   = 7'd64;
  localparam logic [DimW-1:0] ImageHeightRst  = 7'd64;
  localparam logic [RadW-1:0] WindowRadiusRst = 2'd1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETTLE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    cmd_e                      cmd;
    logic [PosW-1:0]           col;
    logic [PosW-1:0]           row;
    logic signed [SampleW-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] median_out;
    logic                      out_of_range;
  } out_item_t;

endpackage

`default_nettype wire

### hdl/windowed_median_filter_2d.sv
// ----------------------------------------------------------------------------
// windowed_median_filter_2d
// Frame store with a median query over a square window clipped to the frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries write and
//   query transactions. A write stores one sample and gives no result; the
//   next transaction is taken in the following cycle. A query gives one
//   result on the output channel (out_valid_o / out_stall_i / out_data_o).
//   The rank is found by a radix selection: the window is walked 16 times,
//   once per sample bit, through the single read port of the frame store,
//   and one masked compare and counter decide each bit. A query outside the
//   frame skips the walk. in_stall_o is high while a query runs.
//   The result sits in an output register; if the receiver stalls, a finished
//   query waits for it to be taken, and the input stays stalled meanwhile.
//   Reset clears the control state and loads the register defaults; the
//   frame store is not cleared and must be written before it is queried.
//   Configuration writes are taken in any cycle through cfg_we_i.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_median_filter_2d #(
  parameter int unsigned MAX_WIDTH  = wmf2d_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = wmf2d_pkg::MaxHeightDef,
  parameter int unsigned MAX_RADIUS = wmf2d_pkg::MaxRadiusDef
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [wmf2d_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire  [wmf2d_pkg::CfgW-1:0]           cfg_data_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wmf2d_pkg::in_item_t                  in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output wmf2d_pkg::out_item_t                 out_data_o
);

  localparam int unsigned Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned WinMax = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int unsigned CntW   = $clog2(WinMax + 1);

  localparam int unsigned SW = wmf2d_pkg::SampleW;
  localparam int unsigned CW = wmf2d_pkg::CoordW;
  localparam int unsigned DW = wmf2d_pkg::DimW;
  localparam int unsigned RW = wmf2d_pkg::RadW;
  localparam int unsigned BW = wmf2d_pkg::BitIdxW;

  localparam logic [SW-1:0] SignFlip = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0] HiSeed   = {{(SW-1){1'b1}}, 1'b0};

  // Configuration registers
  logic [DW-1:0] width_q, height_q;
  logic [RW-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= wmf2d_pkg::ImageWidthRst;
      height_q <= wmf2d_pkg::ImageHeightRst;
      radius_q <= wmf2d_pkg::WindowRadiusRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wmf2d_pkg::RegImageWidth:   width_q  <= cfg_data_i[DW-1:0];
        wmf2d_pkg::RegImageHeight:  height_q <= cfg_data_i[DW-1:0];
        wmf2d_pkg::RegWindowRadius: radius_q <= cfg_data_i[RW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size and radius
  logic [DW-1:0] w_eff, h_eff, w_m1, h_m1;
  logic [RW-1:0] r_eff;

  always_comb begin
    if (width_q == '0)                     w_eff = DW'(1);
    else if (32'(width_q) > MAX_WIDTH)     w_eff = DW'(MAX_WIDTH);
    else                                   w_eff = width_q;
    if (height_q == '0)                    h_eff = DW'(1);
    else if (32'(height_q) > MAX_HEIGHT)   h_eff = DW'(MAX_HEIGHT);
    else                                   h_eff = height_q;
    if (32'(radius_q) > MAX_RADIUS)        r_eff = RW'(MAX_RADIUS);
    else                                   r_eff = radius_q;
    w_m1 = w_eff - DW'(1);
    h_m1 = h_eff - DW'(1);
  end

  logic [CW-1:0] col_x, row_y, col_hi, row_hi;
  logic          in_frame;

  assign col_x    = CW'(in_data_i.col);
  assign row_y    = CW'(in_data_i.row);
  assign col_hi   = col_x + CW'(r_eff);
  assign row_hi   = row_y + CW'(r_eff);
  assign in_frame = (col_x < CW'(w_eff)) && (row_y < CW'(h_eff));

  // Sequencer and datapath registers
  wmf2d_pkg::state_e state_q, state_d;
  logic [CW-1:0] x_q, x_d, y_q, y_d;
  logic [CW-1:0] x1_q, x1_d, x2_q, x2_d, y1_q, y1_d, y2_q, y2_d;
  logic [BW-1:0] bit_q, bit_d;
  logic [SW-1:0] prefix_q, prefix_d;
  logic [CntW-1:0] k_q, k_d, cnt_q, cnt_d, tot_q, tot_d;
  logic          dvld_q, dvld_d;
  logic          oor_q, oor_d;
  logic          out_vld_q, out_vld_d;
  wmf2d_pkg::out_item_t out_q, out_d;

  logic          in_acc;
  logic          mem_we;
  logic [AddrW-1:0] waddr, raddr;
  logic signed [SW-1:0] rdata_q;

  assign in_acc = in_valid_i && !in_stall_o;
  assign mem_we = in_acc && (in_data_i.cmd == wmf2d_pkg::CMD_WRITE) && in_frame;
  assign waddr  = AddrW'(32'(row_y) * MAX_WIDTH + 32'(col_x));
  assign raddr  = AddrW'(32'(y_q) * MAX_WIDTH + 32'(x_q));

  // Frame store: one write and one registered read per cycle
  logic signed [SW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= in_data_i.sample_in;
    end
    rdata_q <= mem[raddr];
  end

  // Shared compare unit: does the sample match the prefix above the current
  // bit and have a zero at that bit (offset binary, so signed order holds)
  logic [SW-1:0]   elem, hi_mask;
  logic            match;
  logic [CntW-1:0] c_next, tot_next, kk;
  logic            last_addr, take_hi;

  always_comb begin
    elem     = rdata_q ^ SignFlip;
    hi_mask  = HiSeed << bit_q;
    match    = (((elem ^ prefix_q) & hi_mask) == '0) && !elem[bit_q];
    c_next   = cnt_q + CntW'(dvld_q && match);
    tot_next = tot_q + CntW'(dvld_q && (bit_q == BW'(SW - 1)));
    kk       = (bit_q == BW'(SW - 1)) ? (tot_next >> 1) : k_q;
    take_hi  = !(kk < c_next);
    last_addr = (x_q == x2_q) && (y_q == y2_q);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wmf2d_pkg::ST_IDLE: begin
        if (in_acc && in_data_i.cmd == wmf2d_pkg::CMD_QUERY) begin
          state_d = in_frame ? wmf2d_pkg::ST_SCAN : wmf2d_pkg::ST_FINISH;
        end
      end
      wmf2d_pkg::ST_SCAN: begin
        if (last_addr) state_d = wmf2d_pkg::ST_SETTLE;
      end
      wmf2d_pkg::ST_SETTLE: begin
        state_d = (bit_q == '0) ? wmf2d_pkg::ST_FINISH : wmf2d_pkg::ST_SCAN;
      end
      wmf2d_pkg::ST_FINISH: begin
        if (!out_vld_q || !out_stall_i) state_d = wmf2d_pkg::ST_IDLE;
      end
      default: state_d = wmf2d_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    x_d = x_q;  y_d = y_q;
    x1_d = x1_q; x2_d = x2_q; y1_d = y1_q; y2_d = y2_q;
    bit_d = bit_q; prefix_d = prefix_q;
    k_d = k_q; cnt_d = cnt_q; tot_d = tot_q;
    dvld_d = 1'b0;
    oor_d = oor_q;
    out_d = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    in_stall_o = (state_q != wmf2d_pkg::ST_IDLE);

    case (state_q)
      wmf2d_pkg::ST_IDLE: begin
        if (in_acc && in_data_i.cmd == wmf2d_pkg::CMD_QUERY) begin
          oor_d    = !in_frame;
          x1_d     = (col_x > CW'(r_eff)) ? col_x - CW'(r_eff) : '0;
          y1_d     = (row_y > CW'(r_eff)) ? row_y - CW'(r_eff) : '0;
          x2_d     = (col_hi > CW'(w_m1)) ? CW'(w_m1) : col_hi;
          y2_d     = (row_hi > CW'(h_m1)) ? CW'(h_m1) : row_hi;
          x_d      = x1_d;
          y_d      = y1_d;
          bit_d    = BW'(SW - 1);
          prefix_d = '0;
          cnt_d    = '0;
          tot_d    = '0;
          k_d      = '0;
        end
      end
      wmf2d_pkg::ST_SCAN: begin
        dvld_d = 1'b1;
        cnt_d  = c_next;
        tot_d  = tot_next;
        // advance down the column, then to the next column
        if (y_q == y2_q) begin
          y_d = y1_q;
          x_d = x_q + CW'(1);
        end else begin
          y_d = y_q + CW'(1);
        end
      end
      wmf2d_pkg::ST_SETTLE: begin
        // last sample of the pass is in; settle this bit
        tot_d = tot_next;
        if (take_hi) begin
          prefix_d[bit_q] = 1'b1;
          k_d = kk - c_next;
        end else begin
          k_d = kk;
        end
        cnt_d = '0;
        x_d   = x1_q;
        y_d   = y1_q;
        if (bit_q != '0) bit_d = bit_q - BW'(1);
      end
      wmf2d_pkg::ST_FINISH: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_d.out_of_range = oor_q;
          out_d.median_out   = oor_q ? '0 : (prefix_q ^ SignFlip);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wmf2d_pkg::ST_IDLE;
      dvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dvld_q    <= dvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;   y_q <= y_d;
    x1_q <= x1_d; x2_q <= x2_d;
    y1_q <= y1_d; y2_q <= y2_d;
    bit_q    <= bit_d;
    prefix_q <= prefix_d;
    k_q      <= k_d;
    cnt_q    <= cnt_d;
    tot_q    <= tot_d;
    oor_q    <= oor_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### hdl/wmf2d_checker.sv
// ----------------------------------------------------------------------------
// wmf2d_checker
// Port-level checks of the windowed median filter, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf2d_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           cfg_we_i,
  input wire [wmf2d_pkg::CfgIdxW-1:0]  cfg_index_i,
  input wire [wmf2d_pkg::CfgW-1:0]     cfg_data_i,
  input wire                           in_valid_i,
  input wire                           in_stall_o,
  input wmf2d_pkg::in_item_t           in_data_i,
  input wire                           out_valid_o,
  input wire                           out_stall_i,
  input wmf2d_pkg::out_item_t          out_data_o
);

  logic cfg_seen;
  assign cfg_seen = cfg_we_i && (cfg_index_i != '0 || cfg_data_i != '0);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // A query transaction blocks the input for at least the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.cmd == wmf2d_pkg::CMD_QUERY
      |=> in_stall_o)
    else $error("query did not block the input");

  // A write transaction completes at once
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.cmd == wmf2d_pkg::CMD_WRITE
      |=> !in_stall_o || cfg_seen)
    else $error("write held the input");

  // A position outside the frame reports a zero median
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_of_range |-> out_data_o.median_out == '0)
    else $error("out-of-range result carries a median");

endmodule

bind windowed_median_filter_2d wmf2d_checker u_wmf2d_checker (.*);

`default_nettype wire
